/* src/slr_pkg.sv */
// Shared types and constants for the stereo linear resampler.
`timescale 1ns / 1ps
package slr_pkg;

  // Sample and register widths
  localparam int SAMPLE_W = 16;
  localparam int INC_W    = 32;
  localparam int SUM_W    = INC_W + 1;

  // Cap on results emitted for one input item
  localparam int MAX_OUT = 64;
  localparam int CNT_W   = $clog2(MAX_OUT);

  // Configuration space: one 32-bit register per word
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_INC = '0;
  localparam logic [INC_W-1:0]     PHASE_INC_RST = 32'h4000_0000;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } slr_state_t;

  // Per-lane strobes from the sequencer
  typedef struct packed {
    logic take;       // latch the current frame
    logic skip_take;  // skipped frame goes straight to prev
    logic mul;        // load the product register
    logic commit;     // current frame becomes prev
  } lane_ctl_t;

endpackage

/* src/slr_in_if.sv */
// Input channel: one stereo frame per item.
`timescale 1ns / 1ps
interface slr_in_if
  import slr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

/* src/slr_out_if.sv */
// Result channel: one interpolated stereo frame per item.
`timescale 1ns / 1ps
interface slr_out_if
  import slr_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       last;

  modport source (output valid, output left_out, output right_out, output last, input ready);
  modport sink   (input valid, input left_out, input right_out, input last, output ready);
endinterface

/* src/slr_lane.sv */
// One channel lane: holds prev/current sample and interpolates between them.
`timescale 1ns / 1ps
module slr_lane
  import slr_pkg::*;
#(
  parameter int COEF_BITS = 15
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lane_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [COEF_BITS-1:0]       coef,
  output logic signed [SAMPLE_W-1:0] result
);

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + COEF_BITS + 1;

  logic signed [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic signed [SAMPLE_W-1:0] cur_r;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   shifted;
  logic signed [PROD_W-1:0]   sum;

  // Difference times unsigned coefficient, registered before the add
  always_comb begin
    diff     = DIFF_W'(cur_r) - DIFF_W'(prev_r);
    prod_nxt = PROD_W'(diff) * PROD_W'($signed({1'b0, coef}));
  end

  // Floor shift and add back; result always lies between prev and cur
  always_comb begin
    shifted = prod_r >>> COEF_BITS;
    sum     = PROD_W'(prev_r) + shifted;
    result  = sum[SAMPLE_W-1:0];
  end

  // Previous sample update
  always_comb begin
    prev_nxt = prev_r;
    if (ctl.skip_take) begin
      prev_nxt = sample_in;
    end else if (ctl.commit) begin
      prev_nxt = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cur_r <= sample_in;
    end
    if (ctl.mul) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

/* src/slr_ctrl.sv */
// Sequencer: phase accumulator, skip count and per-item emission loop.
`timescale 1ns / 1ps
module slr_ctrl
  import slr_pkg::*;
#(
  parameter int PHASE_BITS = 30,
  parameter int COEF_BITS  = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_free,
  input  logic [INC_W-1:0]     phase_inc,
  output logic [COEF_BITS-1:0] coef,
  output lane_ctl_t            lane_ctl,
  output logic                 out_load,
  output logic                 out_last
);

  localparam int SKIP_W = SUM_W - PHASE_BITS;

  slr_state_t              state_r, state_nxt;
  logic [PHASE_BITS-1:0]   frac_r, frac_nxt;
  logic [SKIP_W-1:0]       skip_r, skip_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [SUM_W-1:0]        sum;
  logic [SKIP_W-1:0]       carry;
  logic                    accept;
  logic                    emit;
  logic                    finish;

  // Phase step for the result being emitted
  always_comb begin
    sum    = SUM_W'(frac_r) + SUM_W'(phase_inc);
    carry  = sum[SUM_W-1:PHASE_BITS];
    accept = (state_r == ST_IDLE) && in_valid;
    emit   = (state_r == ST_EMIT) && out_free;
    finish = (carry != '0) || (cnt_r == CNT_W'(MAX_OUT - 1));
  end

  assign coef = frac_r[PHASE_BITS-1 -: COEF_BITS];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (skip_r == '0)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          state_nxt = finish ? ST_IDLE : ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs and datapath next values
  always_comb begin
    in_ready  = 1'b0;
    lane_ctl  = '0;
    out_load  = 1'b0;
    out_last  = 1'b0;
    frac_nxt  = frac_r;
    skip_nxt  = skip_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (skip_r != '0) begin
            lane_ctl.skip_take = 1'b1;
            skip_nxt           = skip_r - 1'b1;
          end else begin
            lane_ctl.take = 1'b1;
            cnt_nxt       = '0;
          end
        end
      end
      ST_MUL: begin
        lane_ctl.mul = 1'b1;
      end
      ST_EMIT: begin
        if (emit) begin
          out_load = 1'b1;
          out_last = finish;
          frac_nxt = sum[PHASE_BITS-1:0];
          cnt_nxt  = cnt_r + 1'b1;
          if (carry != '0) begin
            skip_nxt = carry - 1'b1;
          end
          if (finish) begin
            lane_ctl.commit = 1'b1;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      frac_r  <= '0;
      skip_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      frac_r  <= frac_nxt;
      skip_r  <= skip_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* src/stereo_linear_resampler.sv */
// Data path: a taken item is latched into cur; for each result the product register is loaded,
// then the sum is added into the output register once out_free allows. A skipped frame goes
// straight to prev while idle, and the next item is taken in the cycle after the last result
// of the previous one is loaded.
// Reset (synchronous, rst_n low): sequencer idle, prev samples, phase and skip count
// zero, phase_increment 2^30, output register empty.
`timescale 1ns / 1ps
module stereo_linear_resampler
  import slr_pkg::*;
#(
  parameter int PHASE_BITS = 30,
  parameter int COEF_BITS  = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  slr_in_if.sink                in_chan,
  slr_out_if.source             out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [INC_W-1:0]      cfg_pwdata,
  output logic [INC_W-1:0]      cfg_prdata,
  output logic                  cfg_pready
);

  logic [INC_W-1:0]           inc_r, inc_nxt;
  logic [REG_IDX_W-1:0]       reg_idx;
  logic                       cfg_wr;
  logic [COEF_BITS-1:0]       coef;
  lane_ctl_t                  lane_ctl;
  logic                       out_load;
  logic                       out_last;
  logic                       out_free;
  logic signed [SAMPLE_W-1:0] left_res, right_res;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] left_r, right_r;
  logic                       last_r;

  // Configuration register
  always_comb begin
    reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
    cfg_pready = 1'b1;
    cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
    inc_nxt    = inc_r;
    if (cfg_wr && (reg_idx == REG_PHASE_INC)) begin
      inc_nxt = cfg_pwdata;
    end
    cfg_prdata = (reg_idx == REG_PHASE_INC) ? inc_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r <= PHASE_INC_RST;
    end else begin
      inc_r <= inc_nxt;
    end
  end

  // Sequencer
  slr_ctrl #(
    .PHASE_BITS (PHASE_BITS),
    .COEF_BITS  (COEF_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_free  (out_free),
    .phase_inc (inc_r),
    .coef      (coef),
    .lane_ctl  (lane_ctl),
    .out_load  (out_load),
    .out_last  (out_last)
  );

  // Left and right lanes
  slr_lane #(.COEF_BITS(COEF_BITS)) u_lane_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lane_ctl),
    .sample_in (in_chan.left_sample),
    .coef      (coef),
    .result    (left_res)
  );

  slr_lane #(.COEF_BITS(COEF_BITS)) u_lane_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lane_ctl),
    .sample_in (in_chan.right_sample),
    .coef      (coef),
    .result    (right_res)
  );

  // Merge the lanes into the output register
  always_comb begin
    out_free      = !out_valid_r || out_chan.ready;
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_r  <= left_res;
      right_r <= right_res;
      last_r  <= out_last;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.left_out  = left_r;
  assign out_chan.right_out = right_r;
  assign out_chan.last      = last_r;

endmodule

/* src/slr_checker.sv */
// Port-level checks for the stereo linear resampler, bound to the top level.
`timescale 1ns / 1ps
module slr_checker
  import slr_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] left_out,
  input logic signed [SAMPLE_W-1:0] right_out,
  input logic                       last,
  input logic                       cfg_psel,
  input logic                       cfg_penable,
  input logic                       cfg_pwrite,
  input logic [CFG_ADDR_W-1:0]      cfg_paddr,
  input logic [INC_W-1:0]           cfg_pwdata,
  input logic [INC_W-1:0]           cfg_prdata
);

  logic wr_inc;
  assign wr_inc = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[CFG_ADDR_W-1:2] == REG_PHASE_INC);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled item holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out)
      && $stable(last))
    else $error("stalled output item changed");

  // No new item is taken while an item's results are still being emitted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !last |-> !in_ready)
    else $error("input taken in the middle of an emission run");

  // A written increment reads back
  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    wr_inc ##1 (cfg_paddr[CFG_ADDR_W-1:2] == REG_PHASE_INC)
      |-> cfg_prdata == $past(cfg_pwdata))
    else $error("phase increment readback mismatch");

endmodule

bind stereo_linear_resampler slr_checker u_slr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .left_out    (out_chan.left_out),
  .right_out   (out_chan.right_out),
  .last        (out_chan.last),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);
